FILE: design/ramped_sine_reference_generator_assert.svh
// ----------------------------------------------------------------------------
// Ramped sine reference generator assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RAMPED_SINE_REFERENCE_GENERATOR_ASSERT_SVH
`define RAMPED_SINE_REFERENCE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define RSRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rsrg_pkg.sv
// ----------------------------------------------------------------------------
// rsrg_pkg
// Constants, codes and helpers of the ramped sine reference generator.
// ----------------------------------------------------------------------------
package rsrg_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned TBL_BITS         = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned RAMP_SECONDS     = 3;

  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598668;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;

  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [31:0] ACCEL_DIVISOR = 32'd10000;
  // floor(2^45 / 10000), applied to the item shifted right by 13
  localparam logic [31:0] ACCEL_RECIP   = 32'd3518437208;

  localparam logic [2:0] CFG_CENTER   = 3'd0;
  localparam logic [2:0] CFG_AMP      = 3'd1;
  localparam logic [2:0] CFG_STEP     = 3'd2;
  localparam logic [2:0] CFG_RGAIN    = 3'd3;
  localparam logic [2:0] CFG_RATE     = 3'd4;
  localparam logic [2:0] CFG_TOTAL    = 3'd5;
  localparam logic [2:0] CFG_VAMP     = 3'd6;
  localparam logic [2:0] CFG_AAMP     = 3'd7;

  typedef logic signed [32:0] mul_op_t;
  typedef logic signed [65:0] mul_prod_t;

  localparam mul_prod_t SAT_MAX = 66'sd2147483647;
  localparam mul_prod_t SAT_MIN = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input mul_prod_t v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/ramped_sine_reference_generator.sv
// ----------------------------------------------------------------------------
// Ramped sine reference generator
// One position/velocity/acceleration sample per tick item, sine from a
// Horner polynomial on one shared 33x33 signed multiplier.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i/in_ready_o with restart_i. Each accepted tick
//   gives one sample on out_valid_o/out_ready_i, or none once the run is over.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i at once;
//   write only while no tick is in flight.
//   Throughput: one tick at a time; the multiplier carries the Horner
//   steps of sine (and cosine after start-up) plus the scaling, differencing
//   and divide-by-10000 products in turn, one product per cycle.
//   Ready is high only while the sequencer is idle.
//   Reset: registers take their defaults (sample rate 200, others 0), the
//   run restarts at sample zero and no sample is held.
//   Stall: a finished sample waits in the output register; the next tick is
//   still accepted, and its own result waits until that register is free.
// ----------------------------------------------------------------------------
`include "ramped_sine_reference_generator_assert.svh"

module ramped_sine_reference_generator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    position_o,
  output logic signed [31:0]    velocity_o,
  output logic signed [31:0]    acceleration_o,
  output logic                  last_sample_o
);
  import rsrg_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SX2   = 5'd1;
  localparam logic [4:0] ST_SH0   = 5'd2;
  localparam logic [4:0] ST_SH1   = 5'd3;
  localparam logic [4:0] ST_SH2   = 5'd4;
  localparam logic [4:0] ST_SH3   = 5'd5;
  localparam logic [4:0] ST_SH4   = 5'd6;
  localparam logic [4:0] ST_SSC   = 5'd7;
  localparam logic [4:0] ST_SPOS  = 5'd8;
  localparam logic [4:0] ST_SACC  = 5'd9;
  localparam logic [4:0] ST_SVEL  = 5'd10;
  localparam logic [4:0] ST_SENV  = 5'd11;
  localparam logic [4:0] ST_SRPOS = 5'd12;
  localparam logic [4:0] ST_SRVEL = 5'd13;
  localparam logic [4:0] ST_SRVS  = 5'd14;
  localparam logic [4:0] ST_SRAD  = 5'd15;
  localparam logic [4:0] ST_SRAQ  = 5'd16;
  localparam logic [4:0] ST_SRAR  = 5'd17;
  localparam logic [4:0] ST_SRAM  = 5'd18;
  localparam logic [4:0] ST_SRAC  = 5'd19;
  localparam logic [4:0] ST_SRAF  = 5'd20;
  localparam logic [4:0] ST_SDONE = 5'd21;

  localparam int unsigned LIM_W = 15;

  // configuration
  logic signed [31:0] center_q;
  logic [30:0]        amp_q, rgain_q, vamp_q, aamp_q;
  logic [31:0]        step_q;
  logic [9:0]         rate_q;
  logic [23:0]        total_q;

  // run state and sequencer
  logic [4:0]         state_q, state_d;
  logic [23:0]        n_q;
  logic [31:0]        phase_q;
  logic signed [31:0] prev_pos_q, prev_vel_q;
  logic               fin_q, cos_q, ramp_q;
  logic               out_valid_q;

  // datapath
  mul_prod_t          prod_q, prod_d;
  mul_op_t            op_a, op_b;
  logic [30:0]        x2_q, mag_q;
  logic               neg_q, tneg_q;
  logic signed [31:0] pos_q, vel_q, acc_q;
  logic [42:0]        tmag_q;
  logic [29:0]        q_q;
  logic [15:0]        r_q;
  logic signed [31:0] pos_out_q, vel_out_q, acc_out_q;
  logic               last_out_q;

  logic               accept, load_out, last_now, start_run;
  logic [23:0]        n_eff;
  logic               fin_eff;
  logic [LIM_W-1:0]   ramp_lim;
  logic [1:0]         quad;
  logic [TBL_BITS-1:0] kidx;
  logic [TBL_BITS:0]  kk;
  logic [30:0]        x;
  logic [31:0]        hk, hsub;
  logic [30:0]        sine_raw, mag_new, env;
  logic [31:0]        rnd;
  logic signed [33:0] rnd_s, r_pos, r_neg, pos_sum;
  logic signed [32:0] diff_pos, diff_vel;
  mul_prod_t          pneg;
  logic [42:0]        tabs;
  logic [15:0]        r_new;
  logic [29:0]        q_fin;
  logic signed [31:0] q_s, acc_fin;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign load_out  = (state_q == ST_SDONE) && (!out_valid_q || out_ready_i);
  assign last_now  = (n_q == total_q);

  assign n_eff     = restart_i ? '0 : n_q;
  assign fin_eff   = restart_i ? 1'b0 : fin_q;
  assign start_run = !fin_eff && (n_eff <= total_q);
  assign ramp_lim  = LIM_W'(rate_q) * LIM_W'(RAMP_SECONDS);

  assign quad     = phase_q[31:30] + {1'b0, cos_q};
  assign kidx     = phase_q[29:30-TBL_BITS];
  assign kk       = quad[0] ? ((TBL_BITS+1)'(SINE_TABLE_DEPTH) - {1'b0, kidx})
                            : {1'b0, kidx};
  assign x        = {kk, {(30-TBL_BITS){1'b0}}};

  assign hsub     = hk - prod_q[61:30];
  assign sine_raw = prod_q[60:30];
  assign mag_new  = (sine_raw > Q30_ONE) ? Q30_ONE : sine_raw;
  assign env      = (|prod_q[65:31]) ? 31'h7FFF_FFFF : prod_q[30:0];

  assign rnd      = {1'b0, prod_q[60:30]} + 32'(prod_q[29]);
  assign rnd_s    = $signed({2'b00, rnd});
  assign r_pos    = neg_q ? -rnd_s : rnd_s;
  assign r_neg    = neg_q ? rnd_s : -rnd_s;
  assign pos_sum  = 34'(center_q) + r_pos;

  assign diff_pos = 33'(pos_q) - 33'(prev_pos_q);
  assign diff_vel = 33'(vel_q) - 33'(prev_vel_q);

  assign pneg     = -prod_q;
  assign tabs     = prod_q[65] ? pneg[42:0] : prod_q[42:0];
  assign r_new    = tmag_q[15:0] - prod_q[15:0];
  assign q_fin    = q_q + 30'(r_q >= 16'(ACCEL_DIVISOR))
                        + 30'(r_q >= 16'(2 * ACCEL_DIVISOR));
  assign q_s      = $signed({2'b00, q_fin});
  assign acc_fin  = tneg_q ? -q_s : q_s;

  always_comb begin
    hk = K1;
    unique case (state_q)
      ST_SH1:  hk = K7;
      ST_SH2:  hk = K5;
      ST_SH3:  hk = K3;
      default: hk = K1;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_SX2: begin
        op_a = 33'(x);
        op_b = 33'(x);
      end
      ST_SH0: begin
        op_a = 33'(K9);
        op_b = 33'(prod_q[60:30]);
      end
      ST_SH1, ST_SH2, ST_SH3: begin
        op_a = 33'(hsub);
        op_b = 33'(x2_q);
      end
      ST_SH4: begin
        op_a = 33'(hsub);
        op_b = 33'(x);
      end
      ST_SSC: begin
        if (cos_q) begin
          op_a = 33'(vamp_q);
          op_b = 33'(mag_new);
        end else if (ramp_q) begin
          op_a = 33'(rgain_q);
          op_b = 33'(n_q);
        end else begin
          op_a = 33'(amp_q);
          op_b = 33'(mag_new);
        end
      end
      ST_SENV: begin
        op_a = 33'(env);
        op_b = 33'(mag_q);
      end
      ST_SPOS: begin
        op_a = 33'(aamp_q);
        op_b = 33'(mag_q);
      end
      ST_SRVEL: begin
        op_a = diff_pos;
        op_b = 33'(rate_q);
      end
      ST_SRAD: begin
        op_a = diff_vel;
        op_b = 33'(rate_q);
      end
      ST_SRAR: begin
        op_a = 33'(tmag_q[42:13]);
        op_b = 33'(ACCEL_RECIP);
      end
      ST_SRAM: begin
        op_a = 33'(prod_q[61:32]);
        op_b = 33'(ACCEL_DIVISOR);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  state_d = (accept && start_run) ? ST_SX2 : ST_IDLE;
      ST_SX2:   state_d = ST_SH0;
      ST_SH0:   state_d = ST_SH1;
      ST_SH1:   state_d = ST_SH2;
      ST_SH2:   state_d = ST_SH3;
      ST_SH3:   state_d = ST_SH4;
      ST_SH4:   state_d = ST_SSC;
      ST_SSC: begin
        if (cos_q) begin
          state_d = ST_SVEL;
        end else if (ramp_q) begin
          state_d = ST_SENV;
        end else begin
          state_d = ST_SPOS;
        end
      end
      ST_SPOS:  state_d = ST_SACC;
      ST_SACC:  state_d = ST_SX2;
      ST_SVEL:  state_d = ST_SDONE;
      ST_SENV:  state_d = ST_SRPOS;
      ST_SRPOS: state_d = ST_SRVEL;
      ST_SRVEL: state_d = ST_SRVS;
      ST_SRVS:  state_d = ST_SRAD;
      ST_SRAD:  state_d = ST_SRAQ;
      ST_SRAQ:  state_d = ST_SRAR;
      ST_SRAR:  state_d = ST_SRAM;
      ST_SRAM:  state_d = ST_SRAC;
      ST_SRAC:  state_d = ST_SRAF;
      ST_SRAF:  state_d = ST_SDONE;
      ST_SDONE: state_d = load_out ? ST_IDLE : ST_SDONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      amp_q    <= '0;
      step_q   <= '0;
      rgain_q  <= '0;
      rate_q   <= 10'd200;
      total_q  <= '0;
      vamp_q   <= '0;
      aamp_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CENTER: center_q <= cfg_data_i;
        CFG_AMP:    amp_q    <= cfg_data_i[30:0];
        CFG_STEP:   step_q   <= cfg_data_i;
        CFG_RGAIN:  rgain_q  <= cfg_data_i[30:0];
        CFG_RATE:   rate_q   <= cfg_data_i[9:0];
        CFG_TOTAL:  total_q  <= cfg_data_i[23:0];
        CFG_VAMP:   vamp_q   <= cfg_data_i[30:0];
        CFG_AAMP:   aamp_q   <= cfg_data_i[30:0];
        default:    center_q <= center_q;
      endcase
    end
  end

  // sequencer and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      phase_q     <= '0;
      prev_pos_q  <= '0;
      prev_vel_q  <= '0;
      fin_q       <= 1'b0;
      cos_q       <= 1'b0;
      ramp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        n_q    <= n_eff;
        fin_q  <= !start_run;
        cos_q  <= 1'b0;
        ramp_q <= (n_eff <= 24'(ramp_lim));
        if (restart_i) begin
          phase_q    <= '0;
          prev_pos_q <= '0;
          prev_vel_q <= '0;
        end
      end
      if (state_q == ST_SACC) begin
        cos_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        fin_q       <= last_now;
        phase_q     <= phase_q + step_q;
        if (!last_now) begin
          n_q <= n_q + 24'd1;
        end
        if (ramp_q) begin
          prev_pos_q <= pos_q;
          prev_vel_q <= vel_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_SH0:   x2_q <= prod_q[60:30];
      ST_SSC: begin
        mag_q <= mag_new;
        neg_q <= quad[1];
      end
      ST_SPOS:  pos_q <= sat32(66'(pos_sum));
      ST_SACC:  acc_q <= sat32(66'(r_neg));
      ST_SVEL:  vel_q <= sat32(66'(r_pos));
      ST_SRPOS: pos_q <= sat32(66'(pos_sum));
      ST_SRVS:  vel_q <= sat32(prod_q);
      ST_SRAQ: begin
        tmag_q <= tabs;
        tneg_q <= prod_q[65];
      end
      ST_SRAM:  q_q <= prod_q[61:32];
      ST_SRAC:  r_q <= r_new;
      ST_SRAF:  acc_q <= acc_fin;
      default:  x2_q <= x2_q;
    endcase
    if (load_out) begin
      pos_out_q  <= pos_q;
      vel_out_q  <= vel_q;
      acc_out_q  <= acc_q;
      last_out_q <= last_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_out_q;
  assign velocity_o     = vel_out_q;
  assign acceleration_o = acc_out_q;
  assign last_sample_o  = last_out_q;

  `RSRG_ASSERT_NEXT(a_start_seq, accept && start_run, state_q == ST_SX2,
                    "accepted item did not start the sequencer")
  `RSRG_ASSERT_NOW(a_rem_bound, state_q == ST_SRAF, r_q < 16'(3 * ACCEL_DIVISOR),
                   "divide-by-10000 remainder out of correction range")
  `RSRG_ASSERT_NEXT(a_hold_done, (state_q == ST_SDONE) && out_valid_q && !out_ready_i,
                    state_q == ST_SDONE, "result loaded over a held item")
  `RSRG_ASSERT_NEXT(a_last_fin, load_out && last_now, fin_q && out_valid_q,
                    "last item did not close the run")

endmodule
